[rtl/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the delta timer queue insert block
// widths of the task, wait, slot and count fields, queue depth, and the transaction
// records that travel between neighboring cells
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TID_W       = 8;
  localparam int WAIT_W      = 32;
  localparam int SLOT_W      = 6;

  // search token: remaining wait of the task looking for its place
  typedef struct packed {
    logic              v;
    logic [WAIT_W-1:0] rem;
    logic [TID_W-1:0]  tid;
  } srch_t;

  // displaced entry rippling toward the tail
  typedef struct packed {
    logic              v;
    logic [WAIT_W-1:0] delta;
    logic [TID_W-1:0]  tid;
  } disp_t;

endpackage

[rtl/delta_timer_queue_insert_top.sv]
// ----------------------------------------------------------------------------
// delta_timer_queue_insert_top: insert side of a delta list timer queue
// a row of QUEUE_DEPTH cells holds the ordered entries; an insert walks
// from the head one cell per cycle and reports its slot and stored delta
// ----------------------------------------------------------------------------
//
//  channel   ports                                      transaction taken when
//  -------   -----------------------------------------  ------------------------
//  input     start, busy, in_task_id, in_wait_ticks     start && !busy at clk
//  result    out_valid, out_slot, out_stored_delta,     out_valid at clk
//            out_rejected
//
//  - an insert placed at slot p shows its result after its search token has
//    walked from the head to slot p, one cell per clock, and placed there
//  - the next insert can be taken in the cycle the result is shown; no new
//    insert is taken while one is still in flight
//  - a full queue rejects in the next cycle, with slot and stored delta zero
//  - a displaced entry ripples toward the tail behind the search; later
//    searches trail it and always see settled entries
//  - synchronous active-low reset empties the queue; entry contents are not
//    cleared, only the valid bits
//  - the receiver cannot stall: each result is shown for exactly one cycle
//
module delta_timer_queue_insert_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dtq_pkg::TID_W-1:0]     in_task_id,
  input  logic [dtq_pkg::WAIT_W-1:0]    in_wait_ticks,
  output logic                          out_valid,
  output logic [dtq_pkg::SLOT_W-1:0]    out_slot,
  output logic [dtq_pkg::WAIT_W-1:0]    out_stored_delta,
  output logic                          out_rejected
);
  import dtq_pkg::*;

  // cell chain links; element QUEUE_DEPTH is the tail end of the row
  srch_t             srch_c [QUEUE_DEPTH+1];
  disp_t             disp_c [QUEUE_DEPTH+1];
  logic              place_c [QUEUE_DEPTH];
  logic [WAIT_W-1:0] rpt_delta_c [QUEUE_DEPTH];

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              busy_r, busy_nxt;
  logic              rej_r;
  logic              full;
  logic              accept;
  logic              acc_ins;
  logic              rpt_any;
  logic [SLOT_W-1:0] rpt_slot;
  logic [WAIT_W-1:0] rpt_delta;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign accept  = start && !busy;
  assign acc_ins = accept && !full;

  // new search token enters at the head cell
  always_comb begin
    srch_c[0].v   = acc_ins;
    srch_c[0].rem = in_wait_ticks;
    srch_c[0].tid = in_task_id;
    disp_c[0]     = '0;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    dtq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .srch_i      (srch_c[i]),
      .disp_i      (disp_c[i]),
      .srch_o      (srch_c[i+1]),
      .disp_o      (disp_c[i+1]),
      .place_o     (place_c[i]),
      .rpt_delta_o (rpt_delta_c[i])
    );
  end

  // at most one cell reports in a cycle; gather it by a one-hot or
  always_comb begin
    rpt_any   = 1'b0;
    rpt_slot  = '0;
    rpt_delta = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rpt_any   = rpt_any | place_c[i];
      rpt_slot  = rpt_slot | (place_c[i] ? SLOT_W'(i) : '0);
      rpt_delta = rpt_delta | (place_c[i] ? rpt_delta_c[i] : '0);
    end
  end

  // busy from acceptance of an insert until its placement is reported
  always_comb begin
    busy_nxt = busy_r;
    if (acc_ins) begin
      busy_nxt = 1'b1;
    end else if (rpt_any) begin
      busy_nxt = 1'b0;
    end
  end

  assign count_nxt = acc_ins ? count_r + 1'b1 : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b0;
      rej_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
      rej_r   <= accept && full;
    end
  end

  assign busy             = busy_r && !rpt_any;
  assign out_valid        = rpt_any || rej_r;
  assign out_slot         = rpt_slot;
  assign out_stored_delta = rpt_delta;
  assign out_rejected     = rej_r;

endmodule

[rtl/dtq_cell.sv]
// ----------------------------------------------------------------------------
// dtq_cell: one queue slot of the delta list
// holds one entry, walks the search token past it or places the task here,
// and swaps a displaced entry one slot toward the tail
// ----------------------------------------------------------------------------
module dtq_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dtq_pkg::srch_t        srch_i,
  input  dtq_pkg::disp_t        disp_i,
  output dtq_pkg::srch_t        srch_o,
  output dtq_pkg::disp_t        disp_o,
  output logic                  place_o,
  output logic [dtq_pkg::WAIT_W-1:0] rpt_delta_o
);
  import dtq_pkg::*;

  logic              ent_v_r, ent_v_nxt;
  logic [WAIT_W-1:0] ent_delta_r, ent_delta_nxt;
  logic [TID_W-1:0]  ent_tid_r, ent_tid_nxt;
  srch_t             srch_r;
  disp_t             disp_r;
  logic              rpt_v_r;
  logic [WAIT_W-1:0] rpt_delta_r;
  logic              go_on;
  logic              place;

  // move on while the remaining wait covers this entry's delta
  assign go_on = srch_r.v && ent_v_r && (srch_r.rem >= ent_delta_r);
  assign place = srch_r.v && !go_on;

  always_comb begin
    srch_o.v   = go_on;
    srch_o.rem = srch_r.rem - ent_delta_r;
    srch_o.tid = srch_r.tid;
  end

  always_comb begin
    ent_v_nxt     = ent_v_r;
    ent_delta_nxt = ent_delta_r;
    ent_tid_nxt   = ent_tid_r;
    disp_o.v      = 1'b0;
    disp_o.delta  = ent_delta_r;
    disp_o.tid    = ent_tid_r;
    priority if (place) begin
      // old entry now follows the new task, its delta shrinks by the remainder
      disp_o.v      = ent_v_r;
      disp_o.delta  = ent_delta_r - srch_r.rem;
      ent_v_nxt     = 1'b1;
      ent_delta_nxt = srch_r.rem;
      ent_tid_nxt   = srch_r.tid;
    end else if (disp_r.v) begin
      disp_o.v      = ent_v_r;
      ent_v_nxt     = 1'b1;
      ent_delta_nxt = disp_r.delta;
      ent_tid_nxt   = disp_r.tid;
    end else begin
      // nothing passes through, entry holds
      disp_o.v      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r  <= 1'b0;
      srch_r.v <= 1'b0;
      disp_r.v <= 1'b0;
      rpt_v_r  <= 1'b0;
    end else begin
      ent_v_r <= ent_v_nxt;
      srch_r  <= srch_i;
      disp_r  <= disp_i;
      rpt_v_r <= place;
    end
  end

  always_ff @(posedge clk) begin
    ent_delta_r <= ent_delta_nxt;
    ent_tid_r   <= ent_tid_nxt;
    rpt_delta_r <= srch_r.rem;
  end

  assign place_o     = rpt_v_r;
  assign rpt_delta_o = rpt_delta_r;

endmodule

[rtl/dtq_chk.sv]
// ----------------------------------------------------------------------------
// dtq_chk: port-level checks of the delta timer queue insert block
// watches the command and result ports over time, attached by bind
// ----------------------------------------------------------------------------
module dtq_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          out_valid,
  input  logic [dtq_pkg::SLOT_W-1:0]    out_slot,
  input  logic [dtq_pkg::WAIT_W-1:0]    out_stored_delta,
  input  logic                          out_rejected
);
  import dtq_pkg::*;

  // a rejected transaction carries zero slot and delta
  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> (out_slot == '0) && (out_stored_delta == '0))
    else $error("rejected result with nonzero payload");

  // an accepted transaction is either in progress or answered next cycle
  a_acc_track: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted transaction lost");

  // a result frees the command port in the same cycle
  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while result shown");

  // the reject flag only shows together with the result strobe
  a_rej_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_rejected |-> out_valid)
    else $error("reject flag without result strobe");

  // no result without a pending transaction
  a_no_spur: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !start |=> !out_valid)
    else $error("result with nothing pending");

endmodule

bind delta_timer_queue_insert_top dtq_chk u_dtq_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_slot         (out_slot),
  .out_stored_delta (out_stored_delta),
  .out_rejected     (out_rejected)
);
